FILE: hdl/bfa_pkg.sv
package bfa_pkg;

  localparam int IDX_W   = 10;
  localparam int FIRST_W = 10;
  localparam int COUNT_W = 11;
  localparam int MODE_W  = 2;

  // Wide enough for any word base address and the largest entry count.
  localparam int CMP_W = 18;

  localparam logic [MODE_W-1:0] MODE_USE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

  typedef struct packed {
    logic hit;
    logic was_used;
    logic changed;
    logic has_free;
  } bfa_word_res_t;

endpackage

FILE: hdl/bitmap_first_free_allocator_top.sv
// Bitmap allocator with a first-free search over ENTRIES entries.
// The input channel (in_valid/in_ready) carries one request beat: in_mode
// selects mark used, mark free or report only, and in_index names the entry.
// The result channel (out_valid/out_ready) returns one beat per request: the
// prior state of the indexed bit (0 for report only or an index >= ENTRIES),
// the lowest free entry after the update, a none-free flag, the free count.
// The bitmap lives in a single-port-write RAM of MAP_WORDS words. One word
// unit is reused for every word: each request walks all MAP_WORDS words in
// order, applying the update to the word that holds the index and searching
// each word for a free bit. After the scan a request passes a drain and a
// finish state, and the next request is accepted only once the result is
// loaded into the output register. After reset the block clears the RAM,
// one word per cycle, with in_ready low; then every entry is free.
// The result sits in an output register. A new request may be accepted while
// a result waits; if the receiver still stalls when the next result is done,
// the block holds that result internally and keeps in_ready low until the
// output register frees up.
module bitmap_first_free_allocator_top
  import bfa_pkg::*;
#(
  parameter int ENTRIES   = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [IDX_W-1:0]   in_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_was_used,
  output logic [FIRST_W-1:0] out_first_free,
  output logic               out_none_free,
  output logic [COUNT_W-1:0] out_free_count
);

  localparam int MAP_WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BA        = $clog2(WORD_BITS);
  localparam int FCW       = $clog2(ENTRIES + 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [CMP_W-1:0]     base_r, base_nxt;
  logic                 proc_vld_r, proc_vld_nxt;
  logic [AW-1:0]        proc_addr_r, proc_addr_nxt;
  logic [CMP_W-1:0]     proc_base_r, proc_base_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  logic [CMP_W-1:0]     first_r, first_nxt;
  logic                 was_r, was_nxt;
  logic [FCW-1:0]       free_r, free_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_was_r, out_was_nxt;
  logic [FIRST_W-1:0]   out_first_r, out_first_nxt;
  logic                 out_none_r, out_none_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] unit_word;
  logic [BA-1:0]        unit_pos;
  bfa_word_res_t        unit_res;
  logic                 last_addr;
  logic                 out_load;

  bfa_map_ram #(
    .DEPTH(MAP_WORDS),
    .WIDTH(WORD_BITS),
    .AW   (AW)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  bfa_word_unit #(
    .ENTRIES  (ENTRIES),
    .WORD_BITS(WORD_BITS),
    .BA       (BA)
  ) u_word_unit (
    .word_in (ram_rdata),
    .base    (proc_base_r),
    .idx     (idx_r),
    .mode    (mode_r),
    .word_out(unit_word),
    .pos     (unit_pos),
    .res     (unit_res)
  );

  assign last_addr = addr_r == AW'(MAP_WORDS - 1);
  assign in_ready  = state_r == S_IDLE;
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign ram_re    = state_r == S_SCAN;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_addr_r;
    ram_wdata = unit_word;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = addr_r;
      ram_wdata = '0;
    end else if (proc_vld_r && unit_res.changed) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    base_nxt      = base_r;
    proc_vld_nxt  = 1'b0;
    proc_addr_nxt = addr_r;
    proc_base_nxt = base_r;
    mode_nxt      = mode_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    first_nxt     = first_r;
    was_nxt       = was_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_was_nxt   = out_was_r;
    out_first_nxt = out_first_r;
    out_none_nxt  = out_none_r;
    out_count_nxt = out_count_r;

    case (state_r)
      S_CLEAR: begin
        addr_nxt = addr_r + AW'(1);
        if (last_addr) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          idx_nxt   = in_index;
          addr_nxt  = '0;
          base_nxt  = '0;
          found_nxt = 1'b0;
          first_nxt = '0;
          was_nxt   = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        proc_vld_nxt = 1'b1;
        addr_nxt     = addr_r + AW'(1);
        base_nxt     = base_r + CMP_W'(WORD_BITS);
        if (last_addr) begin
          addr_nxt  = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_was_nxt   = was_r;
          out_first_nxt = found_r ? first_r[FIRST_W-1:0] : '0;
          out_none_nxt  = !found_r;
          out_count_nxt = COUNT_W'(free_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (proc_vld_r) begin
      if (unit_res.hit) begin
        was_nxt = unit_res.was_used;
      end
      if (unit_res.changed) begin
        if (mode_r == MODE_USE) begin
          free_nxt = free_r - FCW'(1);
        end else begin
          free_nxt = free_r + FCW'(1);
        end
      end
      if (!found_r && unit_res.has_free) begin
        found_nxt = 1'b1;
        first_nxt = proc_base_r + CMP_W'(unit_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      proc_vld_r  <= 1'b0;
      free_r      <= FCW'(ENTRIES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      proc_vld_r  <= proc_vld_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    proc_addr_r <= proc_addr_nxt;
    proc_base_r <= proc_base_nxt;
    mode_r      <= mode_nxt;
    idx_r       <= idx_nxt;
    found_r     <= found_nxt;
    first_r     <= first_nxt;
    was_r       <= was_nxt;
    out_was_r   <= out_was_nxt;
    out_first_r <= out_first_nxt;
    out_none_r  <= out_none_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_was_used   = out_was_r;
  assign out_first_free = out_first_r;
  assign out_none_free  = out_none_r;
  assign out_free_count = out_count_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FCW'(ENTRIES))
    else $error("free count exceeds the entry count");

  a_proc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    proc_vld_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("word unit active outside a scan");

  a_found_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |-> (found_r == (free_r != '0)))
    else $error("search result disagrees with the free count");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FINISH) |-> !ram_we)
    else $error("bitmap written outside a clear or scan");

endmodule

FILE: hdl/bfa_map_ram.sv
module bfa_map_ram
  import bfa_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bfa_word_unit.sv
module bfa_word_unit
  import bfa_pkg::*;
#(
  parameter int ENTRIES   = 1024,
  parameter int WORD_BITS = 32,
  parameter int BA        = 5
) (
  input  logic [WORD_BITS-1:0] word_in,
  input  logic [CMP_W-1:0]     base,
  input  logic [IDX_W-1:0]     idx,
  input  logic [MODE_W-1:0]    mode,
  output logic [WORD_BITS-1:0] word_out,
  output logic [BA-1:0]        pos,
  output bfa_word_res_t        res
);

  logic [CMP_W-1:0]     idx_ext;
  logic [CMP_W-1:0]     diff;
  logic [BA-1:0]        bit_sel;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] live_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic                 is_write;
  logic                 hit;
  logic                 was;

  assign idx_ext  = CMP_W'(idx);
  assign diff     = idx_ext - base;
  assign bit_sel  = diff[BA-1:0];
  assign bit_mask = WORD_BITS'(1) << bit_sel;
  assign is_write = (mode == MODE_USE) || (mode == MODE_FREE);
  assign hit      = is_write && (idx_ext >= base)
                    && (idx_ext < base + CMP_W'(WORD_BITS))
                    && (idx_ext < CMP_W'(ENTRIES));
  assign was      = hit && ((word_in & bit_mask) != '0);

  always_comb begin
    word_out = word_in;
    if (hit && (mode == MODE_USE)) begin
      word_out = word_in | bit_mask;
    end else if (hit && (mode == MODE_FREE)) begin
      word_out = word_in & ~bit_mask;
    end
  end

  // Bits past the last entry never count as free.
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      live_mask[j] = (base + CMP_W'(j)) < CMP_W'(ENTRIES);
    end
  end

  assign free_bits = ~word_out & live_mask;

  always_comb begin
    pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        pos = BA'(j);
      end
    end
  end

  assign res.hit      = hit;
  assign res.was_used = was;
  assign res.changed  = hit && (((mode == MODE_USE) && !was) || ((mode == MODE_FREE) && was));
  assign res.has_free = free_bits != '0;

endmodule
